// ===== design/pdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdsr_pkg
// Shared types and constants for the particle density splat and readout unit.
// ----------------------------------------------------------------------------
package pdsr_pkg;

	// item operation codes
	localparam logic OP_PLOT  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZOOM     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 8'd3;

	localparam logic [31:0] ZOOM_RESET = 32'h0001_0000;
	localparam logic [31:0] GAIN_RESET = 32'h0001_0000;

	// queue between the front and the back
	localparam int ITEM_QUEUE_DEPTH = 8;
	localparam int ITEM_QUEUE_CW    = $clog2(ITEM_QUEUE_DEPTH + 1);

	// result queue
	localparam int RES_QUEUE_DEPTH = 2;
	localparam int RES_QUEUE_CW    = $clog2(RES_QUEUE_DEPTH + 1);

	localparam int CELL_INDEX_W = 18;
	localparam logic [7:0] GRAY_MAX = 8'd255;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [31:0]        zoom;
		logic [31:0]        gain;
	} cfg_t;

	typedef struct packed {
		logic [CELL_INDEX_W-1:0] cell_index;
		logic [7:0]              gray_level;
		logic                    frame_end;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

// ===== design/pdsr_fifo.sv =====
// ----------------------------------------------------------------------------
// pdsr_fifo
// Small show-ahead queue with occupancy count.
// ----------------------------------------------------------------------------
module pdsr_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 8,
	localparam int PW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	input  logic          pop,
	output logic [DW-1:0] dout,
	output logic          empty,
	output logic          full,
	output logic [CW-1:0] count
);

	logic [DW-1:0] store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign dout    = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== design/pdsr_front.sv =====
// ----------------------------------------------------------------------------
// pdsr_front
// Input pipeline: maps particle positions onto a grid cell index.
// ----------------------------------------------------------------------------
module pdsr_front
	import pdsr_pkg::*;
#(
	parameter int GRID_WIDTH  = 512,
	parameter int GRID_HEIGHT = 512,
	localparam int AW         = $clog2(GRID_WIDTH * GRID_HEIGHT),
	localparam int XW         = $clog2(GRID_WIDTH),
	localparam int YW         = $clog2(GRID_HEIGHT)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     hold,
	input  logic                     push,
	input  logic                     op,
	input  logic signed [31:0]       particle_x,
	input  logic signed [31:0]       particle_y,
	output logic                     full,
	input  logic [ITEM_QUEUE_CW-1:0] q_count,
	output logic                     q_push,
	output logic                     q_op,
	output logic [AW-1:0]            q_idx
);

	localparam logic [33:0] HALF_X = 34'(GRID_WIDTH / 2);
	localparam logic [33:0] HALF_Y = 34'(GRID_HEIGHT / 2);
	localparam logic [33:0] TOP_X  = 34'(GRID_WIDTH - 1);
	localparam logic [33:0] TOP_Y  = 34'(GRID_HEIGHT - 1);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(GRID_WIDTH);

	function automatic logic [31:0] map_pix(input logic neg, input logic [31:0] p,
		input logic [33:0] half, input logic [33:0] top);
		logic signed [33:0] v;
		v = neg ? -$signed({2'b00, p}) : $signed({2'b00, p});
		v = v + $signed(half);
		if (v < 0) begin
			map_pix = '0;
		end else if (v > $signed(top)) begin
			map_pix = top[31:0];
		end else begin
			map_pix = v[31:0];
		end
	endfunction

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                    op_s1, op_s2, op_s3, op_s4, op_s5;
	logic signed [32:0]      offx_s1, offy_s1;
	logic                    negx_s2, negy_s2, negx_s3, negy_s3;
	logic [32:0]             magx_s2, magy_s2;
	logic [31:0]             pixx_s3, pixy_s3;
	logic [XW-1:0]           x_s4;
	logic [YW-1:0]           y_s4;
	logic [AW-1:0]           idx_s5;
	logic [63:0]             prodx, prody;
	logic [31:0]             mapx, mapy;
	logic [ITEM_QUEUE_CW:0]  occupancy;
	logic                    accept;

	// every item in flight already owns a queue slot
	assign occupancy = (ITEM_QUEUE_CW + 1)'(q_count) + (ITEM_QUEUE_CW + 1)'(v_s1)
		+ (ITEM_QUEUE_CW + 1)'(v_s2) + (ITEM_QUEUE_CW + 1)'(v_s3)
		+ (ITEM_QUEUE_CW + 1)'(v_s4) + (ITEM_QUEUE_CW + 1)'(v_s5);
	assign full   = hold || (occupancy >= (ITEM_QUEUE_CW + 1)'(ITEM_QUEUE_DEPTH));
	assign accept = push && !full;

	assign prodx = 64'(magx_s2[31:0]) * 64'(cfg.zoom);
	assign prody = 64'(magy_s2[31:0]) * 64'(cfg.zoom);
	assign mapx  = map_pix(negx_s3, pixx_s3, HALF_X, TOP_X);
	assign mapy  = map_pix(negy_s3, pixy_s3, HALF_Y, TOP_Y);

	assign q_push = v_s5;
	assign q_op   = op_s5;
	assign q_idx  = idx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op;
		offx_s1 <= {particle_x[31], particle_x} - {cfg.origin_x[31], cfg.origin_x};
		offy_s1 <= {particle_y[31], particle_y} - {cfg.origin_y[31], cfg.origin_y};

		op_s2   <= op_s1;
		negx_s2 <= offx_s1[32];
		negy_s2 <= offy_s1[32];
		magx_s2 <= offx_s1[32] ? 33'(-offx_s1) : 33'(offx_s1);
		magy_s2 <= offy_s1[32] ? 33'(-offy_s1) : 33'(offy_s1);

		// a magnitude of exactly 2^32 scales to the zoom value itself
		op_s3   <= op_s2;
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		pixx_s3 <= magx_s2[32] ? cfg.zoom : prodx[63:32];
		pixy_s3 <= magy_s2[32] ? cfg.zoom : prody[63:32];

		op_s4 <= op_s3;
		x_s4  <= mapx[XW-1:0];
		y_s4  <= mapy[YW-1:0];

		op_s5  <= op_s4;
		idx_s5 <= AW'(y_s4) * ROW_STRIDE + AW'(x_s4);
	end

endmodule

// ===== design/pdsr_back.sv =====
// ----------------------------------------------------------------------------
// pdsr_back
// Density memory with read-modify-write sequencer and readout scaling.
// ----------------------------------------------------------------------------
module pdsr_back
	import pdsr_pkg::*;
#(
	parameter int GRID_WIDTH  = 512,
	parameter int GRID_HEIGHT = 512,
	parameter int COUNT_BITS  = 16,
	localparam int CELLS      = GRID_WIDTH * GRID_HEIGHT,
	localparam int AW         = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          q_empty,
	input  logic          q_op,
	input  logic [AW-1:0] q_idx,
	output logic          q_pop,
	input  logic          r_full,
	output logic          r_push,
	output res_t          r_data,
	output logic          busy
);

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam int CB = COUNT_BITS;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SUM
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       scan_q;
	logic                op_q;
	logic [63:0]         vb_q;
	logic [CB+31:0]      phi_q;
	logic [CB-1:0]       plo_q;
	logic [CB-1:0]       mem [CELLS];
	logic [CB-1:0]       rd_q;
	logic                start;
	logic [AW-1:0]       rd_addr;
	logic                we;
	logic [AW-1:0]       wa;
	logic [CB-1:0]       wd;
	logic [CB-1:0]       inc;
	logic [CB+31:0]      prod_hi;
	logic [CB+31:0]      prod_lo;
	logic [CB:0]         sum;
	logic [7:0]          gray;
	logic [AW+17:0]      addr_wide;

	assign busy    = (state_q == ST_CLEAR);
	assign start   = (state_q == ST_IDLE) && !q_empty && (q_op == OP_PLOT || !r_full);
	assign q_pop   = start;
	assign rd_addr = (q_op == OP_DRAIN) ? scan_q : q_idx;

	assign inc = (&rd_q) ? rd_q : rd_q + 1'b1;
	assign we  = (state_q == ST_CLEAR) || (state_q == ST_MOD);
	assign wa  = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign wd  = (state_q == ST_MOD && op_q == OP_PLOT) ? inc : '0;

	assign prod_hi = (CB + 32)'(rd_q) * (CB + 32)'(vb_q[63:32]);
	assign prod_lo = (CB + 32)'(rd_q) * (CB + 32)'(vb_q[31:0]);

	// the high partial product alone decides saturation when it reaches 256
	assign sum  = (CB + 1)'(phi_q[7:0]) + (CB + 1)'(plo_q);
	assign gray = (|phi_q[CB+31:8] || sum > (CB + 1)'(GRAY_MAX)) ? GRAY_MAX : sum[7:0];

	assign addr_wide = (AW + 18)'(addr_q);

	assign r_push            = (state_q == ST_SUM);
	assign r_data.cell_index = addr_wide[CELL_INDEX_W-1:0];
	assign r_data.gray_level = gray;
	assign r_data.frame_end  = (addr_q == LAST_CELL);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			scan_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= (op_q == OP_DRAIN) ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					state_q <= ST_IDLE;
					scan_q  <= (scan_q == LAST_CELL) ? '0 : scan_q + 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		vb_q <= 64'(cfg.zoom) * 64'(cfg.gain);
		if (start) begin
			op_q   <= q_op;
			addr_q <= rd_addr;
		end
		if (state_q == ST_MOD) begin
			phi_q <= prod_hi;
			plo_q <= prod_lo[CB+31:32];
		end
	end

endmodule

// ===== design/particle_density_splat_and_readout_unit.sv =====
// ----------------------------------------------------------------------------
// particle_density_splat_and_readout_unit
// Splats particle positions into a density grid and drains it as gray pixels.
// ----------------------------------------------------------------------------
// Plot items enter a five-stage mapping pipeline and wait in an eight-entry
// queue; drain items take the same path so they see every earlier plot. The
// back end owns the single-port-write density memory and handles one item at
// a time: a plot reads the cell, then writes back the saturated count, and a
// drain reads the cell, then clears it and multiplies, then saturates and
// queues the pixel. The memory read-modify-write loop means the back end takes
// no new item until it is through with the last one. After reset the memory
// is cleared one cell per cycle, with full held high; configuration writes are
// taken at any time. Results come out of a two-entry queue, so a stalled reader
// stops the back end only when a drain comes up while both entries are taken.
module particle_density_splat_and_readout_unit
	import pdsr_pkg::*;
#(
	parameter int GRID_WIDTH  = 512,
	parameter int GRID_HEIGHT = 512,
	parameter int COUNT_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 op,
	input  logic signed [31:0]   particle_x,
	input  logic signed [31:0]   particle_y,
	output logic                 empty,
	input  logic                 pop,
	output logic [17:0]          cell_index,
	output logic [7:0]           gray_level,
	output logic [31:0]          rgba_word,
	output logic                 frame_end
);

	localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

	cfg_t                     cfg_q;
	logic                     busy;
	logic                     iq_push, iq_pop, iq_empty, iq_full;
	logic                     iq_op_in, iq_op_out;
	logic [AW-1:0]            iq_idx_in, iq_idx_out;
	logic [ITEM_QUEUE_CW-1:0] iq_count;
	logic                     rq_push, rq_full;
	res_t                     rq_din, rq_dout;
	logic [RES_QUEUE_CW-1:0]  rq_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.zoom     <= ZOOM_RESET;
			cfg_q.gain     <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				CFG_ZOOM:     cfg_q.zoom     <= cfg_data;
				CFG_GAIN:     cfg_q.gain     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pdsr_front #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.hold      (busy),
		.push      (push),
		.op        (op),
		.particle_x(particle_x),
		.particle_y(particle_y),
		.full      (full),
		.q_count   (iq_count),
		.q_push    (iq_push),
		.q_op      (iq_op_in),
		.q_idx     (iq_idx_in)
	);

	pdsr_fifo #(
		.DW   (AW + 1),
		.DEPTH(ITEM_QUEUE_DEPTH)
	) u_item_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (iq_push),
		.din   ({iq_op_in, iq_idx_in}),
		.pop   (iq_pop),
		.dout  ({iq_op_out, iq_idx_out}),
		.empty (iq_empty),
		.full  (iq_full),
		.count (iq_count)
	);

	pdsr_back #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(iq_empty),
		.q_op   (iq_op_out),
		.q_idx  (iq_idx_out),
		.q_pop  (iq_pop),
		.r_full (rq_full),
		.r_push (rq_push),
		.r_data (rq_din),
		.busy   (busy)
	);

	pdsr_fifo #(
		.DW   (RES_W),
		.DEPTH(RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push),
		.din   (rq_din),
		.pop   (pop),
		.dout  (rq_dout),
		.empty (empty),
		.full  (rq_full),
		.count (rq_count)
	);

	assign cell_index = rq_dout.cell_index;
	assign gray_level = rq_dout.gray_level;
	assign rgba_word  = {4{rq_dout.gray_level}};
	assign frame_end  = rq_dout.frame_end;

	// the front reserves a slot for every item in flight
	a_item_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		iq_full |-> !iq_push)
		else $error("item queue pushed while full");

	// the back starts a drain only with room for its result
	a_res_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(rq_count == RES_QUEUE_CW'(RES_QUEUE_DEPTH)) |-> !rq_push)
		else $error("result queue pushed while full");

	// nothing leaves the item queue while the memory is being cleared
	a_no_work_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (full && !iq_pop))
		else $error("item taken during memory clear");

endmodule
